// File: sv/x86_shift_subtract_flags_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef X86_SHIFT_SUBTRACT_FLAGS_UNIT_DEFINES_SVH
`define X86_SHIFT_SUBTRACT_FLAGS_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define XSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define XSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/xsf_pkg.sv
// Package with types, opcodes and helpers for the shift and subtract flags unit.
`timescale 1ns / 1ps
package xsf_pkg;
  localparam int unsigned MaxWidthDef = 64;
  localparam int unsigned DataW = 64;
  localparam int unsigned FlagW = 6;

  localparam logic [2:0] OpSub  = 3'd0;
  localparam logic [2:0] OpSbb  = 3'd1;
  localparam logic [2:0] OpSal  = 3'd2;
  localparam logic [2:0] OpShr  = 3'd3;
  localparam logic [2:0] OpSar  = 3'd4;
  localparam logic [2:0] OpShld = 3'd5;
  localparam logic [2:0] OpShrd = 3'd6;
  localparam logic [2:0] OpStc  = 3'd7;

  localparam int unsigned FCf = 0;
  localparam int unsigned FPf = 1;
  localparam int unsigned FAf = 2;
  localparam int unsigned FZf = 3;
  localparam int unsigned FSf = 4;
  localparam int unsigned FOf = 5;

  localparam logic [5:0] WideCountMask = 6'h3F;
  localparam logic [5:0] NarrowCountMask = 6'h1F;
  localparam logic [3:0] ShldRefillMask = 4'hF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  size_code;
    logic [1:0]  source_size_code;
    logic [63:0] dest_value;
    logic [63:0] source_value;
    logic [7:0]  shift_count;
    logic        wide_count;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        write_dest;
    logic [5:0]  flags_out;
  } out_word_t;

  // Control from the sequencer to the shift datapath.
  typedef struct packed {
    logic       load;
    logic       step;
    logic [2:0] op;
    logic [1:0] size;
  } sh_ctrl_t;

  // Mask of a width code saturated at the given maximum width.
  function automatic logic [63:0] width_mask(input logic [1:0] code, input int unsigned maxw);
    logic [63:0] m;
    begin
      unique case (code)
        2'd0: m = 64'hFF;
        2'd1: m = 64'hFFFF;
        2'd2: m = 64'hFFFF_FFFF;
        default: m = '1;
      endcase
      if (maxw < 64) m = m & ((64'd1 << maxw) - 64'd1);
      width_mask = m;
    end
  endfunction
endpackage

// File: sv/xsf_shift_core.sv
// Shared one-bit shift datapath that steps the destination and shift-in source.
`timescale 1ns / 1ps
module xsf_shift_core import xsf_pkg::*; (
  input  logic        clk,
  input  sh_ctrl_t    ctrl,
  input  logic [63:0] load_d,
  input  logic [63:0] load_s,
  input  logic [63:0] mask,
  input  logic [63:0] sign,
  input  logic [5:0]  step_idx,
  output logic [63:0] res,
  output logic        cf
);
  logic [63:0] r_r, r_nxt, s_r, s_nxt, d0_r, d0_nxt;
  logic        cf_r, cf_nxt;
  logic        top, out_lsb, src_top;
  logic [63:0] src_use;

  always_comb begin
    r_nxt = r_r;
    s_nxt = s_r;
    d0_nxt = d0_r;
    cf_nxt = cf_r;
    top = |(r_r & sign);
    out_lsb = r_r[0];
    src_use = s_r;
    if (ctrl.op == OpShld && ctrl.size == 2'd1 && step_idx != 6'd0 &&
        (step_idx[3:0] & ShldRefillMask) == 4'd0) begin
      src_use = d0_r;
    end
    src_top = |(src_use & sign);
    if (ctrl.load) begin
      r_nxt = load_d;
      s_nxt = load_s;
      d0_nxt = load_d;
      cf_nxt = 1'b0;
    end else if (ctrl.step) begin
      unique case (ctrl.op)
        OpSal: begin
          cf_nxt = top;
          r_nxt = (r_r << 1) & mask;
        end
        OpShr: begin
          cf_nxt = out_lsb;
          r_nxt = r_r >> 1;
        end
        OpSar: begin
          cf_nxt = out_lsb;
          r_nxt = (r_r >> 1) | (d0_r & sign);
        end
        OpShld: begin
          cf_nxt = top;
          r_nxt = ((r_r << 1) & mask) | {63'd0, src_top};
          s_nxt = (src_use << 1) & mask;
        end
        default: begin
          cf_nxt = out_lsb;
          r_nxt = (r_r >> 1) | (s_r[0] ? sign : 64'd0);
          s_nxt = (s_r >> 1) | (out_lsb ? sign : 64'd0);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    s_r <= s_nxt;
    d0_r <= d0_nxt;
    cf_r <= cf_nxt;
  end

  assign res = r_r;
  assign cf = cf_r;
endmodule

// File: sv/x86_shift_subtract_flags_unit.sv
// Top level of the x86 shift and subtract unit with status flags.
`timescale 1ns / 1ps
//  channel | ports                        | direction | payload
//  in      | in_valid, in_stall, in_word  | receive   | in_word_t
//  out     | out_valid, out_stall, out_word | send    | out_word_t
// Subtract and STC words go from accept to result through load, compute and
// flag steps. Shifts step one bit per cycle through the shared one-bit shift
// datapath for the masked count; the run state then sees the remaining count
// reach zero and moves on to the flag step.
// Reset clears the sequencer and the stored flags to zero.
// While out_stall holds, the result stays in the output register and no new
// word is accepted; in_stall is high whenever the unit is busy.
module x86_shift_subtract_flags_unit import xsf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [5:0]  cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [2:0]  op_r;
  logic [1:0]  size_r;
  logic [63:0] mask_r, sign_r, d_r, s_r;
  out_word_t   out_r, out_nxt;
  logic [63:0] mask_c, smask_c, s_ext, res;
  logic        cf_sh;
  logic [5:0]  cnt_c;
  sh_ctrl_t    ctrl;
  logic        acc;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != StIdle);
  assign out_valid = (state_r == StOut);
  assign out_word = out_r;

  always_comb begin
    mask_c = width_mask(in_word.size_code, MAX_WIDTH);
    smask_c = width_mask(in_word.source_size_code, MAX_WIDTH);
    s_ext = in_word.source_value & smask_c;
    if (smask_c != '1 && |(s_ext & ((smask_c >> 1) + 64'd1))) s_ext = s_ext | ~smask_c;
    cnt_c = in_word.shift_count[5:0] & (in_word.wide_count ? WideCountMask : NarrowCountMask);
  end

  assign ctrl.load = acc;
  assign ctrl.step = (state_r == StRun) && (cnt_r != 6'd0);
  assign ctrl.op = op_r;
  assign ctrl.size = size_r;

  xsf_shift_core u_core (
    .clk(clk), .ctrl(ctrl), .load_d(in_word.dest_value & mask_c),
    .load_s(in_word.source_value & mask_c), .mask(mask_r), .sign(sign_r),
    .step_idx(idx_r), .res(res), .cf(cf_sh)
  );

  function automatic logic [5:0] psz(input logic [63:0] r, input logic [63:0] sg);
    logic [5:0] f;
    begin
      f = '0;
      f[FPf] = ~^r[7:0];
      f[FZf] = (r == 64'd0);
      f[FSf] = |(r & sg);
      psz = f;
    end
  endfunction

  always_comb begin
    logic [63:0] r;
    logic [5:0]  f;
    logic        bin;
    state_nxt = state_r;
    flags_nxt = flags_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    out_nxt = out_r;
    r = '0;
    f = '0;
    bin = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (acc) begin
          state_nxt = (in_word.opcode == OpSub || in_word.opcode == OpSbb ||
                       in_word.opcode == OpStc) ? StFin : StRun;
          cnt_nxt = cnt_c;
          idx_nxt = '0;
        end
      end
      StRun: begin
        if (cnt_r != 6'd0) begin
          cnt_nxt = cnt_r - 6'd1;
          idx_nxt = idx_r + 6'd1;
        end else begin
          state_nxt = StFin;
        end
      end
      StFin: begin
        state_nxt = StOut;
        if (op_r == OpStc) begin
          flags_nxt = flags_r;
          flags_nxt[FCf] = 1'b1;
          out_nxt.result_value = '0;
          out_nxt.write_dest = 1'b0;
          out_nxt.flags_out = flags_nxt;
        end else if (op_r == OpSub || op_r == OpSbb) begin
          bin = (op_r == OpSbb) && flags_r[FCf];
          r = (d_r - s_r - {63'd0, bin}) & mask_r;
          f = psz(r, sign_r);
          f[FCf] = (d_r < s_r) || (bin && d_r == s_r);
          f[FOf] = |(((d_r ^ s_r) & (d_r ^ r)) & sign_r);
          f[FAf] = d_r[4] ^ s_r[4] ^ r[4];
          flags_nxt = f;
          out_nxt.result_value = r;
          out_nxt.write_dest = 1'b1;
          out_nxt.flags_out = f;
        end else if (idx_r == 6'd0) begin
          out_nxt.result_value = d_r;
          out_nxt.write_dest = 1'b1;
          out_nxt.flags_out = flags_r;
        end else begin
          r = res & mask_r;
          f = psz(r, sign_r);
          f[FAf] = flags_r[FAf];
          f[FCf] = cf_sh;
          if (idx_r == 6'd1) begin
            priority if (op_r == OpSal) f[FOf] = (|(r & sign_r)) ^ cf_sh;
            else if (op_r == OpShr) f[FOf] = |(d_r & sign_r);
            else if (op_r == OpShld || op_r == OpShrd) f[FOf] = |((r ^ d_r) & sign_r);
            else f[FOf] = 1'b0;
          end
          flags_nxt = f;
          out_nxt.result_value = r;
          out_nxt.write_dest = 1'b1;
          out_nxt.flags_out = f;
        end
      end
      default: begin
        if (!out_stall) state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      flags_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      flags_r <= flags_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (acc) begin
      op_r <= in_word.opcode;
      size_r <= in_word.size_code;
      mask_r <= mask_c;
      sign_r <= (mask_c >> 1) + 64'd1;
      d_r <= in_word.dest_value & mask_c;
      s_r <= s_ext & mask_c;
    end
  end
endmodule

// File: sv/xsf_checker.sv
// Port-level checker for the shift and subtract flags unit, bound to the top level.
`timescale 1ns / 1ps
`include "x86_shift_subtract_flags_unit_defines.svh"
module xsf_checker import xsf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);
  `XSF_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, in_stall)
  `XSF_ASSERT_NEXT(a_acc_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
  `XSF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
  `XSF_ASSERT_IMP(a_stc, clk, rst_n, out_valid && !out_word.write_dest,
                  out_word.flags_out[FCf] && out_word.result_value == 64'd0)
endmodule

bind x86_shift_subtract_flags_unit xsf_checker u_xsf_checker (.*);

// File: tb/x86_shift_subtract_flags_unit_tb.sv
// Self-checking testbench for the x86 shift and subtract flags unit.
`timescale 1ns / 1ps
module x86_shift_subtract_flags_unit_tb;
  import xsf_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // The sender and receiver idle percentages change from phase to phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;

  // Shadow copy of the stored status flags, advanced once per accepted word.
  logic [5:0] model_flags = '0;
  out_word_t  pending_results[$];

  x86_shift_subtract_flags_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #6 clk = ~clk;

  function automatic int unsigned op_width(input logic [1:0] code);
    op_width = 8 << code;
  endfunction

  function automatic logic [63:0] op_mask(input int unsigned w);
    op_mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // PF, ZF and SF of a result at the given sign position.
  function automatic logic [5:0] result_flags(input logic [63:0] r, input logic [63:0] sgn);
    logic [5:0] f;
    f = '0;
    f[FPf] = ~^r[7:0];
    f[FZf] = (r == 64'd0);
    f[FSf] = |(r & sgn);
    result_flags = f;
  endfunction

  // Computes the result word of one instruction and updates the shadow flags.
  function automatic out_word_t execute_insn(input in_word_t w);
    out_word_t  res;
    int unsigned dw, sw, cnt;
    logic [63:0] m, sm, sgn, d, s, r, src, ob;
    logic [5:0]  f;
    logic        cf, ovf;
    dw = op_width(w.size_code);
    sw = op_width(w.source_size_code);
    m = op_mask(dw);
    sgn = 64'd1 << (dw - 1);
    d = w.dest_value & m;
    s = w.source_value;
    cnt = 32'(w.shift_count & {2'b00, (w.wide_count ? WideCountMask : NarrowCountMask)});
    f = model_flags;
    r = '0;
    cf = 1'b0;
    res.write_dest = 1'b1;
    if (w.opcode == OpStc) begin
      model_flags[FCf] = 1'b1;
      res.result_value = '0;
      res.write_dest = 1'b0;
      res.flags_out = model_flags;
      return res;
    end
    if (w.opcode == OpSub || w.opcode == OpSbb) begin
      // The subtrahend is sign extended from its own width, then truncated.
      logic borrow;
      borrow = (w.opcode == OpSbb) && f[FCf];
      sm = op_mask(sw);
      s &= sm;
      if (sw < 64 && s[sw-1]) s |= ~sm;
      s &= m;
      r = (d - s - {63'd0, borrow}) & m;
      f = '0;
      f[FCf] = (d < s) || (borrow && d == s);
      f[FOf] = |(((d ^ s) & (d ^ r)) & sgn);
      f[FAf] = d[4] ^ s[4] ^ r[4];
      f |= result_flags(r, sgn);
    end else if (cnt == 0) begin
      r = d;
    end else begin
      src = s & m;
      r = d;
      for (int unsigned i = 0; i < cnt; i++) begin
        case (w.opcode)
          OpSal: begin
            cf = |(r & sgn);
            r = (r << 1) & m;
          end
          OpShr: begin
            cf = r[0];
            r >>= 1;
          end
          OpSar: begin
            cf = r[0];
            r = (r >> 1) | (d & sgn);
          end
          OpShld: begin
            // At 16 bits the shift-in source refills from the destination.
            if (dw == 16 && i > 0 && (i % 16) == 0) src = d;
            cf = |(r & sgn);
            r = ((r << 1) & m) | {63'd0, |(src & sgn)};
            src = (src << 1) & m;
          end
          default: begin
            ob = r[0] ? sgn : 64'd0;
            cf = r[0];
            r >>= 1;
            if (src[0]) r |= sgn;
            src = (src >> 1) | ob;
          end
        endcase
      end
      f &= (6'd1 << FAf);
      f[FCf] = cf;
      if (cnt == 1) begin
        ovf = 1'b0;
        if (w.opcode == OpSal) ovf = (|(r & sgn)) != cf;
        else if (w.opcode == OpShr) ovf = |(d & sgn);
        else if (w.opcode == OpShld || w.opcode == OpShrd) ovf = |((r ^ d) & sgn);
        f[FOf] = ovf;
      end
      f |= result_flags(r, sgn);
    end
    model_flags = f;
    res.result_value = r & m;
    res.flags_out = f;
    return res;
  endfunction

  // Sends one word, idling first at the current rate, and records its result.
  // Valid stays high after an accept only when the next word follows at once.
  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(execute_insn(w));
  endtask

  // Watches the result channel, drives receiver stalls and counts quiet cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: actual %h", $time, out_word);
          failures++;
        end else begin
          out_word_t exp_w;
          exp_w = pending_results.pop_front();
          if (out_word.result_value !== exp_w.result_value) begin
            $display("%0t result_value: expected %h actual %h", $time,
                     exp_w.result_value, out_word.result_value);
            failures++;
          end
          if (out_word.write_dest !== exp_w.write_dest) begin
            $display("%0t write_dest: expected %b actual %b", $time,
                     exp_w.write_dest, out_word.write_dest);
            failures++;
          end
          if (out_word.flags_out !== exp_w.flags_out) begin
            $display("%0t flags_out: expected %b actual %b", $time,
                     exp_w.flags_out, out_word.flags_out);
            failures++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic in_word_t rand_word();
    in_word_t w;
    w.opcode = 3'($urandom_range(7));
    w.size_code = 2'($urandom_range(3));
    w.source_size_code = 2'($urandom_range(3));
    w.dest_value = {$urandom, $urandom};
    w.source_value = {$urandom, $urandom};
    // Favor small counts, while still covering 0, 1 and the full range.
    case ($urandom_range(3))
      0: w.shift_count = 8'($urandom_range(2));
      1: w.shift_count = 8'($urandom_range(255));
      default: w.shift_count = 8'($urandom_range(40));
    endcase
    w.wide_count = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic in_word_t make_word(input logic [2:0] op, input logic [1:0] sz,
                                         input logic [1:0] ssz, input logic [63:0] d,
                                         input logic [63:0] s, input logic [7:0] c,
                                         input logic wc);
    in_word_t w;
    w = '{op, sz, ssz, d, s, c, wc};
    return w;
  endfunction

  // Directed cases: operand extremes, each opcode, zero count, count of one,
  // counts beyond the width, the 16-bit SHLD refill, and SBB with a borrow.
  task automatic test_directed();
    send_word(make_word(OpSub, 2'd0, 2'd0, 64'h0, 64'h1, 8'd0, 1'b0));
    send_word(make_word(OpSbb, 2'd0, 2'd0, 64'h5, 64'h5, 8'd0, 1'b0));
    send_word(make_word(OpSub, 2'd3, 2'd0, '1, 64'h80, 8'd0, 1'b0));
    send_word(make_word(OpSub, 2'd1, 2'd3, 64'h8000, '1, 8'hFF, 1'b1));
    send_word(make_word(OpSub, 2'd3, 2'd3, 64'h8000_0000_0000_0000, 64'h1, 8'd0, 1'b0));
    send_word(make_word(OpStc, 2'd3, 2'd3, '1, '1, 8'hFF, 1'b1));
    send_word(make_word(OpSbb, 2'd2, 2'd1, 64'h0, 64'h0, 8'd0, 1'b0));
    send_word(make_word(OpSal, 2'd0, 2'd0, 64'hC0, 64'h0, 8'd1, 1'b0));
    send_word(make_word(OpShr, 2'd3, 2'd0, '1, 64'h0, 8'd1, 1'b1));
    send_word(make_word(OpSar, 2'd0, 2'd0, 64'h81, 64'h0, 8'd1, 1'b0));
    send_word(make_word(OpShld, 2'd2, 2'd0, 64'h4000_0000, '1, 8'd1, 1'b0));
    send_word(make_word(OpShrd, 2'd1, 2'd0, 64'h1, '1, 8'd1, 1'b0));
    send_word(make_word(OpSal, 2'd1, 2'd0, 64'h1234, 64'h0, 8'hE0, 1'b0));
    send_word(make_word(OpShr, 2'd3, 2'd0, '1, 64'h0, 8'hFF, 1'b1));
    send_word(make_word(OpSar, 2'd0, 2'd0, 64'h80, 64'h0, 8'd31, 1'b0));
    send_word(make_word(OpShld, 2'd1, 2'd0, 64'hA5C3, 64'h1E0F, 8'd31, 1'b0));
    send_word(make_word(OpShld, 2'd1, 2'd0, 64'hFFFF_0001, 64'h8001, 8'd63, 1'b1));
    send_word(make_word(OpShrd, 2'd0, 2'd0, 64'h96, 64'h3C, 8'd27, 1'b0));
    send_word(make_word(OpShrd, 2'd3, 2'd0, 64'h1, '1, 8'd63, 1'b1));
    send_word(make_word(OpSal, 2'd3, 2'd0, '1, '1, 8'd64, 1'b1));
  endtask

  task automatic test_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_word(rand_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 72;
    test_directed();
    test_random(200);
    send_idle_pct = 72;
    recv_idle_pct = 38;
    test_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(230);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/xsf_pkg.sv
sv/xsf_shift_core.sv
sv/x86_shift_subtract_flags_unit.sv
sv/xsf_checker.sv
tb/x86_shift_subtract_flags_unit_tb.sv
